[hw/rtl/bsrf_pkg.sv]
// Shared types, widths and codes of the bisection root finder.
package bsrf_pkg;

   localparam int BSRF_X_W         = 32;
   localparam int BSRF_EXP_W       = 4;
   localparam int BSRF_TOL_W       = 31;
   localparam int BSRF_ITER_W      = 10;
   localparam int BSRF_MAG_W       = 47;
   localparam int BSRF_F_W         = BSRF_MAG_W + 1;
   localparam int BSRF_STATUS_W    = 2;
   localparam int BSRF_CSR_IDX_W   = 3;
   localparam int BSRF_CSR_DATA_W  = 32;

   localparam int DEF_MAX_EXPONENT = 15;
   localparam int DEF_FRAC_BITS    = 16;

   localparam logic [BSRF_MAG_W-1:0] BSRF_SAT_LIM = {BSRF_MAG_W{1'b1}};

   localparam logic [BSRF_EXP_W-1:0]  RST_EXPONENT       = 4'd2;
   localparam logic [BSRF_X_W-1:0]    RST_OFFSET         = 32'd0;
   localparam logic [BSRF_TOL_W-1:0]  RST_TOLERANCE      = 31'd1;
   localparam logic [BSRF_ITER_W-1:0] RST_MAX_ITERATIONS = 10'd1000;

   localparam logic [BSRF_CSR_IDX_W-1:0] CSR_COEFFICIENT    = 3'd0;
   localparam logic [BSRF_CSR_IDX_W-1:0] CSR_EXPONENT       = 3'd1;
   localparam logic [BSRF_CSR_IDX_W-1:0] CSR_OFFSET         = 3'd2;
   localparam logic [BSRF_CSR_IDX_W-1:0] CSR_TOLERANCE      = 3'd3;
   localparam logic [BSRF_CSR_IDX_W-1:0] CSR_MAX_ITERATIONS = 3'd4;

   localparam logic [BSRF_STATUS_W-1:0] STATUS_CONVERGED = 2'd0;
   localparam logic [BSRF_STATUS_W-1:0] STATUS_LOW_ROOT  = 2'd1;
   localparam logic [BSRF_STATUS_W-1:0] STATUS_HIGH_ROOT = 2'd2;
   localparam logic [BSRF_STATUS_W-1:0] STATUS_LIMIT     = 2'd3;

   typedef struct packed {
      logic signed [BSRF_X_W-1:0] coefficient;
      logic [BSRF_EXP_W-1:0]      exponent;
      logic signed [BSRF_X_W-1:0] offset;
   } bsrf_fcfg_type;

endpackage

[hw/rtl/bsrf_if.sv]
// Request and response channel interfaces of the bisection root finder.
interface bsrf_req_if;
   import bsrf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [BSRF_X_W-1:0] interval_low;
   logic signed [BSRF_X_W-1:0] interval_high;
   modport source (output valid, interval_low, interval_high, input ready);
   modport sink   (input valid, interval_low, interval_high, output ready);
endinterface

interface bsrf_rsp_if;
   import bsrf_pkg::*;
   logic                       valid;
   logic                       ready;
   logic signed [BSRF_X_W-1:0] root_estimate;
   logic [BSRF_MAG_W-1:0]      residual;
   logic [BSRF_STATUS_W-1:0]   status;
   logic [BSRF_ITER_W-1:0]     iterations_used;
   modport source (output valid, root_estimate, residual, status, iterations_used,
                   input ready);
   modport sink   (input valid, root_estimate, residual, status, iterations_used,
                   output ready);
endinterface

[hw/rtl/bisection_root_finder.sv]
// Top level of the bisection root finder for f(x) = k*x^n + c in signed fixed point.
//
// One request carries an interval; the block bisects it and returns one response with
// the root estimate, |f(mid)|, a status and the iteration count. Jobs run one at a time
// and req ready is low while a job runs. All multiplications go through one shared
// multiplier in the evaluator: each evaluation of f makes n+1 passes through it (n the
// clamped exponent), an iteration takes three evaluations (two when the low end is an
// exact root) plus one decision step, and a job takes up to max_iterations iterations
// (a zero limit counts as one). A finished response waits in an output register while
// the next request is taken.
module bisection_root_finder #(
   parameter int MAX_EXPONENT = bsrf_pkg::DEF_MAX_EXPONENT,
   parameter int FRAC_BITS    = bsrf_pkg::DEF_FRAC_BITS
) (
   input  logic                                        clock,
   input  logic                                        reset,
   bsrf_req_if.sink                                    req_bus,
   bsrf_rsp_if.source                                  rsp_bus,
   input  logic                                        csr_we,
   input  logic [bsrf_pkg::BSRF_CSR_IDX_W-1:0]         csr_index,
   input  logic [bsrf_pkg::BSRF_CSR_DATA_W-1:0]        csr_wdata
);
   import bsrf_pkg::*;

   localparam logic [BSRF_X_W-1:0] ONE = BSRF_X_W'(1) << FRAC_BITS;

   typedef enum logic [2:0] {
      S_IDLE, S_EVAL_LO, S_EVAL_HI, S_EVAL_MID, S_DECIDE, S_FINISH
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [BSRF_X_W-1:0]  coef_ff, coef_in;
   logic [BSRF_EXP_W-1:0]       exp_ff, exp_in;
   logic signed [BSRF_X_W-1:0]  offs_ff, offs_in;
   logic [BSRF_TOL_W-1:0]       tol_ff, tol_in;
   logic [BSRF_ITER_W-1:0]      max_iter_ff, max_iter_in;

   logic signed [BSRF_X_W-1:0]  lo_ff, lo_in;
   logic signed [BSRF_X_W-1:0]  hi_ff, hi_in;
   logic signed [BSRF_X_W-1:0]  mid_ff, mid_in;
   logic [BSRF_ITER_W-1:0]      limit_ff, limit_in;
   logic [BSRF_ITER_W-1:0]      iter_ff, iter_in;
   logic signed [BSRF_F_W-1:0]  fa_ff, fa_in;
   logic signed [BSRF_F_W-1:0]  fb_ff, fb_in;
   logic signed [BSRF_F_W-1:0]  fm_ff, fm_in;
   logic                        low_root_ff, low_root_in;
   logic                        high_root_ff, high_root_in;
   logic                        start_ff, start_in;

   logic signed [BSRF_X_W-1:0]  res_root_ff, res_root_in;
   logic [BSRF_MAG_W-1:0]       res_resid_ff, res_resid_in;
   logic [BSRF_STATUS_W-1:0]    res_status_ff, res_status_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   logic signed [BSRF_X_W-1:0]  out_root_ff, out_root_in;
   logic [BSRF_MAG_W-1:0]       out_resid_ff, out_resid_in;
   logic [BSRF_STATUS_W-1:0]    out_status_ff, out_status_in;
   logic [BSRF_ITER_W-1:0]      out_iter_ff, out_iter_in;

   bsrf_fcfg_type               fcfg;
   logic signed [BSRF_X_W-1:0]  eval_x;
   logic                        eval_done;
   logic signed [BSRF_F_W-1:0]  eval_f;
   logic [BSRF_X_W:0]           span;
   logic signed [BSRF_X_W-1:0]  mid_next;
   logic [BSRF_MAG_W-1:0]       resid_mag;
   logic                        fa_neg, fa_pos, fb_neg, fb_pos, fm_neg, fm_pos;

   assign fcfg.coefficient = coef_ff;
   assign fcfg.exponent    = exp_ff;
   assign fcfg.offset      = offs_ff;

   assign eval_x = (state_ff == S_EVAL_LO) ? lo_ff :
                   (state_ff == S_EVAL_HI) ? hi_ff : mid_ff;

   bsrf_eval #(
      .MAX_EXPONENT (MAX_EXPONENT),
      .FRAC_BITS    (FRAC_BITS)
   ) u_eval (
      .clock (clock),
      .reset (reset),
      .start (start_ff),
      .x     (eval_x),
      .fcfg  (fcfg),
      .done  (eval_done),
      .f     (eval_f)
   );

   assign span      = {hi_ff[BSRF_X_W-1], hi_ff} - {lo_ff[BSRF_X_W-1], lo_ff};
   assign mid_next  = lo_ff + BSRF_X_W'(span[BSRF_X_W:1]);
   assign resid_mag = fm_ff[BSRF_F_W-1] ? BSRF_MAG_W'(-fm_ff) : BSRF_MAG_W'(fm_ff);
   assign fa_neg    = fa_ff[BSRF_F_W-1];
   assign fa_pos    = !fa_ff[BSRF_F_W-1] && (fa_ff != '0);
   assign fb_neg    = fb_ff[BSRF_F_W-1];
   assign fb_pos    = !fb_ff[BSRF_F_W-1] && (fb_ff != '0);
   assign fm_neg    = fm_ff[BSRF_F_W-1];
   assign fm_pos    = !fm_ff[BSRF_F_W-1] && (fm_ff != '0);

   // configuration writes
   always_comb begin
      coef_in     = coef_ff;
      exp_in      = exp_ff;
      offs_in     = offs_ff;
      tol_in      = tol_ff;
      max_iter_in = max_iter_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_COEFFICIENT:    coef_in     = BSRF_X_W'(csr_wdata);
            CSR_EXPONENT:       exp_in      = csr_wdata[BSRF_EXP_W-1:0];
            CSR_OFFSET:         offs_in     = BSRF_X_W'(csr_wdata);
            CSR_TOLERANCE:      tol_in      = csr_wdata[BSRF_TOL_W-1:0];
            CSR_MAX_ITERATIONS: max_iter_in = csr_wdata[BSRF_ITER_W-1:0];
            default: ;
         endcase
      end
   end

   // job sequencer
   always_comb begin
      state_in      = state_ff;
      lo_in         = lo_ff;
      hi_in         = hi_ff;
      mid_in        = mid_ff;
      limit_in      = limit_ff;
      iter_in       = iter_ff;
      fa_in         = fa_ff;
      fb_in         = fb_ff;
      fm_in         = fm_ff;
      low_root_in   = low_root_ff;
      high_root_in  = high_root_ff;
      start_in      = 1'b0;
      res_root_in   = res_root_ff;
      res_resid_in  = res_resid_ff;
      res_status_in = res_status_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_bus.ready;
      out_root_in   = out_root_ff;
      out_resid_in  = out_resid_ff;
      out_status_in = out_status_ff;
      out_iter_in   = out_iter_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_bus.valid) begin
               if (req_bus.interval_low > req_bus.interval_high) begin
                  lo_in = req_bus.interval_high;
                  hi_in = req_bus.interval_low;
               end else begin
                  lo_in = req_bus.interval_low;
                  hi_in = req_bus.interval_high;
               end
               limit_in = (max_iter_ff == '0) ? BSRF_ITER_W'(1) : max_iter_ff;
               iter_in  = '0;
               start_in = 1'b1;
               state_in = S_EVAL_LO;
            end
         end
         S_EVAL_LO: begin
            if (eval_done) begin
               fa_in        = eval_f;
               iter_in      = iter_ff + BSRF_ITER_W'(1);
               low_root_in  = (eval_f == '0);
               high_root_in = 1'b0;
               start_in     = 1'b1;
               if (eval_f == '0) begin
                  mid_in   = mid_next;
                  state_in = S_EVAL_MID;
               end else begin
                  state_in = S_EVAL_HI;
               end
            end
         end
         S_EVAL_HI: begin
            if (eval_done) begin
               fb_in        = eval_f;
               high_root_in = (eval_f == '0);
               mid_in       = mid_next;
               start_in     = 1'b1;
               state_in     = S_EVAL_MID;
            end
         end
         S_EVAL_MID: begin
            if (eval_done) begin
               fm_in    = eval_f;
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            res_resid_in = resid_mag;
            res_root_in  = mid_ff;
            if (low_root_ff) begin
               res_root_in   = lo_ff;
               res_status_in = STATUS_LOW_ROOT;
               state_in      = S_FINISH;
            end else if (high_root_ff) begin
               res_root_in   = hi_ff;
               res_status_in = STATUS_HIGH_ROOT;
               state_in      = S_FINISH;
            end else begin
               if (fa_neg && fb_pos) begin
                  if (fm_pos) begin
                     hi_in = mid_ff;
                  end else begin
                     lo_in = mid_ff;
                  end
               end else if (fa_pos && fb_neg) begin
                  if (fm_neg) begin
                     hi_in = mid_ff;
                  end else begin
                     lo_in = mid_ff;
                  end
               end
               if (resid_mag <= BSRF_MAG_W'(tol_ff)) begin
                  res_status_in = STATUS_CONVERGED;
                  state_in      = S_FINISH;
               end else if (iter_ff >= limit_ff) begin
                  res_status_in = STATUS_LIMIT;
                  state_in      = S_FINISH;
               end else begin
                  start_in = 1'b1;
                  state_in = S_EVAL_LO;
               end
            end
         end
         S_FINISH: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_valid_in  = 1'b1;
               out_root_in   = res_root_ff;
               out_resid_in  = res_resid_ff;
               out_status_in = res_status_ff;
               out_iter_in   = iter_ff;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         start_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         coef_ff      <= ONE;
         exp_ff       <= RST_EXPONENT;
         offs_ff      <= RST_OFFSET;
         tol_ff       <= RST_TOLERANCE;
         max_iter_ff  <= RST_MAX_ITERATIONS;
         iter_ff      <= '0;
         limit_ff     <= RST_MAX_ITERATIONS;
      end else begin
         state_ff     <= state_in;
         start_ff     <= start_in;
         rsp_valid_ff <= rsp_valid_in;
         coef_ff      <= coef_in;
         exp_ff       <= exp_in;
         offs_ff      <= offs_in;
         tol_ff       <= tol_in;
         max_iter_ff  <= max_iter_in;
         iter_ff      <= iter_in;
         limit_ff     <= limit_in;
      end
      lo_ff         <= lo_in;
      hi_ff         <= hi_in;
      mid_ff        <= mid_in;
      fa_ff         <= fa_in;
      fb_ff         <= fb_in;
      fm_ff         <= fm_in;
      low_root_ff   <= low_root_in;
      high_root_ff  <= high_root_in;
      res_root_ff   <= res_root_in;
      res_resid_ff  <= res_resid_in;
      res_status_ff <= res_status_in;
      out_root_ff   <= out_root_in;
      out_resid_ff  <= out_resid_in;
      out_status_ff <= out_status_in;
      out_iter_ff   <= out_iter_in;
   end

   assign req_bus.ready           = (state_ff == S_IDLE);
   assign rsp_bus.valid           = rsp_valid_ff;
   assign rsp_bus.root_estimate   = out_root_ff;
   assign rsp_bus.residual        = out_resid_ff;
   assign rsp_bus.status          = out_status_ff;
   assign rsp_bus.iterations_used = out_iter_ff;

`ifndef NO_ASSERTIONS
   a_iter_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (out_iter_ff != '0))
      else $error("response with zero iterations");

   a_interval_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_EVAL_HI || state_ff == S_EVAL_MID || state_ff == S_DECIDE)
      |-> (lo_ff <= hi_ff))
      else $error("interval ends out of order");

   a_iter_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_IDLE) |-> (iter_ff <= limit_ff))
      else $error("iteration count beyond limit");

   a_done_expected: assert property (@(posedge clock) disable iff (reset)
      eval_done |-> (state_ff == S_EVAL_LO || state_ff == S_EVAL_HI ||
                     state_ff == S_EVAL_MID))
      else $error("evaluator finished outside an evaluation step");

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      start_ff |=> !eval_done)
      else $error("evaluator finished right after start");
`endif

endmodule

[hw/rtl/bsrf_eval.sv]
// Polynomial term evaluator k*x^n+c on one shared saturating fixed-point multiplier.
module bsrf_eval #(
   parameter int MAX_EXPONENT = bsrf_pkg::DEF_MAX_EXPONENT,
   parameter int FRAC_BITS    = bsrf_pkg::DEF_FRAC_BITS
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [bsrf_pkg::BSRF_X_W-1:0] x,
   input  bsrf_pkg::bsrf_fcfg_type              fcfg,
   output logic                                 done,
   output logic signed [bsrf_pkg::BSRF_F_W-1:0] f
);
   import bsrf_pkg::*;

   localparam int AH_W   = BSRF_MAG_W - FRAC_BITS;
   localparam int MUL_AW = (AH_W > FRAC_BITS) ? AH_W : FRAC_BITS;
   localparam int PW     = MUL_AW + BSRF_X_W;
   localparam int CNT_W  = $clog2(MAX_EXPONENT + 1);
   localparam int CMP_W  = (CNT_W > BSRF_EXP_W) ? CNT_W : BSRF_EXP_W;
   localparam int SUM_W  = BSRF_MAG_W + 2;
   localparam logic [BSRF_MAG_W-1:0] ONE = BSRF_MAG_W'(1) << FRAC_BITS;
   localparam logic signed [SUM_W-1:0] SUM_SAT_HI = SUM_W'(BSRF_SAT_LIM);
   localparam logic signed [SUM_W-1:0] SUM_SAT_LO = -SUM_SAT_HI;

   typedef enum logic [2:0] {
      E_IDLE, E_LOAD, E_MUL_HI, E_MUL_LO, E_ACC, E_ADD
   } state_type;

   state_type                   state_ff, state_in;
   logic signed [BSRF_X_W-1:0]  x_ff, x_in;
   logic [CNT_W-1:0]            cnt_ff, cnt_in;
   logic [BSRF_MAG_W-1:0]       acc_mag_ff, acc_mag_in;
   logic                        acc_neg_ff, acc_neg_in;
   logic [BSRF_X_W-1:0]         b_mag_ff, b_mag_in;
   logic                        b_neg_ff, b_neg_in;
   logic [PW-1:0]               p_hi_ff, p_hi_in;
   logic [PW-1:0]               p_lo_ff, p_lo_in;
   logic                        done_ff, done_in;
   logic signed [BSRF_F_W-1:0]  f_ff, f_in;

   logic [CMP_W-1:0]            exp_wide;
   logic [CNT_W-1:0]            exp_clamped;
   logic signed [BSRF_X_W-1:0]  b_sel;
   logic [MUL_AW-1:0]           mul_a;
   logic [PW-1:0]               prod;
   logic [PW-1:0]               lo_shift;
   logic [BSRF_MAG_W:0]         m_sum;
   logic [BSRF_MAG_W-1:0]       m_sat;
   logic signed [SUM_W-1:0]     acc_signed;
   logic signed [SUM_W-1:0]     f_sum;

   assign exp_wide    = CMP_W'(fcfg.exponent);
   assign exp_clamped = (exp_wide > CMP_W'(MAX_EXPONENT)) ? CNT_W'(MAX_EXPONENT)
                                                          : CNT_W'(fcfg.exponent);
   assign b_sel    = (cnt_ff != '0) ? x_ff : fcfg.coefficient;
   assign mul_a    = (state_ff == E_MUL_HI) ? MUL_AW'(acc_mag_ff[BSRF_MAG_W-1:FRAC_BITS])
                                            : MUL_AW'(acc_mag_ff[FRAC_BITS-1:0]);
   assign prod     = PW'(mul_a) * PW'(b_mag_ff);
   assign lo_shift = p_lo_ff >> FRAC_BITS;
   assign m_sum    = (BSRF_MAG_W+1)'(p_hi_ff[BSRF_MAG_W-1:0])
                   + (BSRF_MAG_W+1)'(lo_shift);
   assign m_sat    = ((p_hi_ff > PW'(BSRF_SAT_LIM)) || (m_sum > (BSRF_MAG_W+1)'(BSRF_SAT_LIM)))
                   ? BSRF_SAT_LIM : m_sum[BSRF_MAG_W-1:0];
   assign acc_signed = acc_neg_ff ? -SUM_W'(acc_mag_ff) : SUM_W'(acc_mag_ff);
   assign f_sum      = acc_signed + SUM_W'(fcfg.offset);

   always_comb begin
      state_in   = state_ff;
      x_in       = x_ff;
      cnt_in     = cnt_ff;
      acc_mag_in = acc_mag_ff;
      acc_neg_in = acc_neg_ff;
      b_mag_in   = b_mag_ff;
      b_neg_in   = b_neg_ff;
      p_hi_in    = p_hi_ff;
      p_lo_in    = p_lo_ff;
      done_in    = 1'b0;
      f_in       = f_ff;
      unique case (state_ff)
         E_IDLE: begin
            if (start) begin
               x_in       = x;
               cnt_in     = exp_clamped;
               acc_mag_in = ONE;
               acc_neg_in = 1'b0;
               state_in   = E_LOAD;
            end
         end
         E_LOAD: begin
            b_neg_in = b_sel[BSRF_X_W-1];
            b_mag_in = b_sel[BSRF_X_W-1] ? BSRF_X_W'(-b_sel) : BSRF_X_W'(b_sel);
            state_in = E_MUL_HI;
         end
         E_MUL_HI: begin
            p_hi_in  = prod;
            state_in = E_MUL_LO;
         end
         E_MUL_LO: begin
            p_lo_in  = prod;
            state_in = E_ACC;
         end
         E_ACC: begin
            acc_mag_in = m_sat;
            acc_neg_in = (acc_neg_ff != b_neg_ff) && (m_sat != '0);
            if (cnt_ff != '0) begin
               cnt_in   = cnt_ff - CNT_W'(1);
               state_in = E_LOAD;
            end else begin
               state_in = E_ADD;
            end
         end
         E_ADD: begin
            if (f_sum > SUM_SAT_HI) begin
               f_in = BSRF_F_W'(BSRF_SAT_LIM);
            end else if (f_sum < SUM_SAT_LO) begin
               f_in = -BSRF_F_W'(BSRF_SAT_LIM);
            end else begin
               f_in = BSRF_F_W'(f_sum);
            end
            done_in  = 1'b1;
            state_in = E_IDLE;
         end
         default: state_in = E_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= E_IDLE;
         done_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         done_ff  <= done_in;
      end
      x_ff       <= x_in;
      cnt_ff     <= cnt_in;
      acc_mag_ff <= acc_mag_in;
      acc_neg_ff <= acc_neg_in;
      b_mag_ff   <= b_mag_in;
      b_neg_ff   <= b_neg_in;
      p_hi_ff    <= p_hi_in;
      p_lo_ff    <= p_lo_in;
      f_ff       <= f_in;
   end

   assign done = done_ff;
   assign f    = f_ff;

endmodule
